FILE: design/partitioned_lru_status_cache_assert.svh
// ----------------------------------------------------------------------------
// partitioned lru status cache assertion macros
// shared property forms for the cache's internal checks
// ----------------------------------------------------------------------------
`ifndef PARTITIONED_LRU_STATUS_CACHE_ASSERT_SVH
`define PARTITIONED_LRU_STATUS_CACHE_ASSERT_SVH

// same-cycle implication, muted during reset
`define PLC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plc check failed");

// next-cycle implication, muted during reset
`define PLC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plc check failed");

`endif

FILE: design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// shared constants and codes of the partitioned lru status cache
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   localparam int PLC_PARTITIONS = 4;
   localparam int PLC_WAYS       = 16;

   localparam int KEY_W   = 64;
   localparam int HASH_W  = 32;
   localparam int CSN_W   = 64;
   localparam int CLOG_W  = 2;
   localparam int REFS_W  = 32;
   localparam int TOTAL_W = 64;
   localparam int THR_W   = 5;

   localparam logic [THR_W-1:0] THR_RESET = 5'd16;

   // request beat: tdata = xid, hash_code, new_csn, clog_status; tuser = mode
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 168;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // csr map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVICT_THRESHOLD = 5'h00;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVICTIONS_LO    = 5'h04;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVICTIONS_HI    = 5'h08;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVICT_REFS_LO   = 5'h0c;
   localparam logic [CSR_ADDR_W-1:0] CSR_EVICT_REFS_HI   = 5'h10;

   typedef struct packed {
      logic [REFS_W-1:0] evicted_hits;
      logic [KEY_W-1:0]  evicted_xid;
      logic              evicted;
      logic [CSN_W-1:0]  csn_out;
      logic              hit;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/plc_ram.sv
// ----------------------------------------------------------------------------
// plc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/partitioned_lru_status_cache.sv
// ----------------------------------------------------------------------------
// partitioned_lru_status_cache
// cache of transaction ids with commit sequence numbers, split into
// hash-selected partitions, each a fully associative lru set
// ----------------------------------------------------------------------------
// Takes one request beat per clock while the response register is free or
// being taken, and returns one response beat per request. On acceptance the
// partition (hash_code modulo PARTITIONS) addresses a row ram holding key,
// csn, status, age and hit count of every way; the staged beat then compares
// all ways of that row at once, picks the lru tail (age equal to fill count
// minus one), applies eviction, promotion or insertion, writes the row back
// and loads the response register. The row just written is forwarded to a
// following beat on the same partition, so back-to-back beats never stall;
// only a full response register holds the pipe. Valid bits and fill counts
// live in flops cleared by reset; no clearing pass is needed. Insert evicts
// the tail when the fill count is nonzero and reaches evict_threshold
// (clamped to the way count), even when the key is present. Totals of
// evictions and evicted hit counts can be read over the csr port at
// 0x04/0x08 and 0x0c/0x10 (low and high words); evict_threshold is at 0x00.
// ----------------------------------------------------------------------------
`default_nettype none

`include "partitioned_lru_status_cache_assert.svh"

module partitioned_lru_status_cache #(
   parameter int PARTITIONS         = plc_pkg::PLC_PARTITIONS,
   parameter int WAYS_PER_PARTITION = plc_pkg::PLC_WAYS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // csr port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [plc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [plc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [plc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // xid[63:0], hash_code[95:64], new_csn[159:96], clog_status[161:160], zero pad
   input  wire logic [plc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[0]
   input  wire logic [0:0]                         req_tuser,
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hit[0], csn_out[64:1], evicted[65], evicted_xid[129:66],
   // evicted_hits[161:130], zero pad
   output logic      [plc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import plc_pkg::*;

   localparam int WAYS    = WAYS_PER_PARTITION;
   localparam int PART_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int AGE_W   = $clog2(WAYS);
   localparam int CNT_W   = $clog2(WAYS + 1);
   localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int ENTRY_W = KEY_W + CSN_W + CLOG_W + AGE_W + REFS_W;
   localparam int ROW_W   = WAYS * ENTRY_W;
   // field offsets inside one way's slice of a row
   localparam int OFS_CSN  = KEY_W;
   localparam int OFS_CLOG = OFS_CSN + CSN_W;
   localparam int OFS_AGE  = OFS_CLOG + CLOG_W;
   localparam int OFS_REFS = OFS_AGE + AGE_W;
   localparam int RSP_PAD  = RSP_DATA_W - $bits(rsp_type);

   // ------------------------------------------------------------------------
   // request unpack and partition select
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0]  req_xid;
   logic [HASH_W-1:0] req_hash;
   logic [CSN_W-1:0]  req_csn;
   logic [CLOG_W-1:0] req_clog;
   logic [PART_W-1:0] req_part;
   logic              req_accept;

   assign req_xid    = req_tdata[63:0];
   assign req_hash   = req_tdata[95:64];
   assign req_csn    = req_tdata[159:96];
   assign req_clog   = req_tdata[161:160];
   assign req_accept = req_tvalid && req_tready;

   generate
      if ((PARTITIONS & (PARTITIONS - 1)) == 0) begin : g_part_mask
         // power of two: low hash bits
         assign req_part = PART_W'(req_hash & HASH_W'(PARTITIONS - 1));
      end else begin : g_part_recip
         // fold bytes by 256^i mod P, then reciprocal multiply and one correction
         localparam int unsigned B1 = 256 % PARTITIONS;
         localparam int unsigned B2 = 65536 % PARTITIONS;
         localparam int unsigned B3 = 16777216 % PARTITIONS;
         localparam longint unsigned RECIP = (64'd1 << 32) / PARTITIONS;
         logic [16:0] fold;
         logic [48:0] prod;
         logic [16:0] quo;
         logic [16:0] rem_est;
         logic [16:0] rem_fix;
         always_comb begin
            fold = 17'(req_hash[7:0]) + 17'(req_hash[15:8]) * 17'(B1)
                 + 17'(req_hash[23:16]) * 17'(B2) + 17'(req_hash[31:24]) * 17'(B3);
            prod = 49'(fold) * 49'(RECIP[31:0]);
            quo  = prod[48:32];
            rem_est = fold - 17'(quo * 17'(PARTITIONS));
            rem_fix = (rem_est >= 17'(PARTITIONS)) ? rem_est - 17'(PARTITIONS) : rem_est;
         end
         assign req_part = rem_fix[PART_W-1:0];
      end
   endgenerate

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_mode_ff;
   logic [KEY_W-1:0]     stage_xid_ff;
   logic [CSN_W-1:0]     stage_csn_ff;
   logic [CLOG_W-1:0]    stage_clog_ff;
   logic [PART_W-1:0]    stage_part_ff;

   logic                 fwd_valid_ff;
   logic [PART_W-1:0]    fwd_part_ff;
   logic [ROW_W-1:0]     fwd_row_ff;

   logic [WAYS-1:0]      valid_ff [PARTITIONS];
   logic [CNT_W-1:0]     used_ff  [PARTITIONS];

   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [TOTAL_W-1:0]   tot_evict_ff, tot_evict_in;
   logic [TOTAL_W-1:0]   tot_refs_ff, tot_refs_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic                 proc;      // stage item is resolved this cycle
   logic [ROW_W-1:0]     ram_row;
   logic [ROW_W-1:0]     row_cur;
   logic [ROW_W-1:0]     row_next;
   logic [WAYS-1:0]      valid_row_next;
   logic [CNT_W-1:0]     used_next;
   rsp_type              rsp_next;

   assign proc           = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready     = !stage_valid_ff || proc;
   assign stage_valid_in = req_accept ? 1'b1 : (proc ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = proc ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   // row ram: one row per partition, all ways side by side
   plc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (PARTITIONS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (proc),
      .wr_addr (stage_part_ff),
      .wr_data (row_next),
      .rd_en   (req_accept),
      .rd_addr (req_part),
      .rd_data (ram_row)
   );

   // the last row written is newer than a ram read issued on the same edge
   assign row_cur = (fwd_valid_ff && fwd_part_ff == stage_part_ff) ? fwd_row_ff : ram_row;

   // ------------------------------------------------------------------------
   // row resolve
   // ------------------------------------------------------------------------
   logic [WAYS-1:0]   valid_row;
   logic [CNT_W-1:0]  used_cur;
   logic [KEY_W-1:0]  way_key  [WAYS];
   logic [CSN_W-1:0]  way_csn  [WAYS];
   logic [AGE_W-1:0]  way_age  [WAYS];
   logic [REFS_W-1:0] way_refs [WAYS];
   logic [WAYS-1:0]   hit_vec;
   logic [WAYS-1:0]   tail_vec;
   logic [WAYS-1:0]   valid_after;
   logic [WAYS-1:0]   free_vec;
   logic [WAYS-1:0]   first_free;
   logic              hit_any;
   logic              found_after;
   logic              is_insert;
   logic              evict_now;
   logic              add_new;
   logic              do_promote;
   logic [AGE_W-1:0]  hit_age;
   logic [CSN_W-1:0]  hit_csn;
   logic [KEY_W-1:0]  tail_key;
   logic [REFS_W-1:0] tail_refs;
   logic [CMP_W-1:0]  thr_eff;
   logic [AGE_W-1:0]  tail_age;
   logic [WAYS-1:0]   promote_set;

   always_comb begin
      valid_row = valid_ff[stage_part_ff];
      used_cur  = used_ff[stage_part_ff];
      is_insert = (stage_mode_ff == MODE_INSERT);
      hit_age   = '0;
      hit_csn   = '0;
      tail_key  = '0;
      tail_refs = '0;
      tail_age  = AGE_W'(used_cur - CNT_W'(1));
      for (int w = 0; w < WAYS; w++) begin
         way_key[w]  = row_cur[w*ENTRY_W +: KEY_W];
         way_csn[w]  = row_cur[w*ENTRY_W + OFS_CSN +: CSN_W];
         way_age[w]  = row_cur[w*ENTRY_W + OFS_AGE +: AGE_W];
         way_refs[w] = row_cur[w*ENTRY_W + OFS_REFS +: REFS_W];
         hit_vec[w]  = valid_row[w] && (way_key[w] == stage_xid_ff);
         // ages in a partition are a permutation of 0 .. used-1
         tail_vec[w] = valid_row[w] && (way_age[w] == tail_age);
         hit_age     = hit_age   | (hit_vec[w]  ? way_age[w]  : '0);
         hit_csn     = hit_csn   | (hit_vec[w]  ? way_csn[w]  : '0);
         tail_key    = tail_key  | (tail_vec[w] ? way_key[w]  : '0);
         tail_refs   = tail_refs | (tail_vec[w] ? way_refs[w] : '0);
      end
      hit_any = |hit_vec;

      // threshold above the way count acts as the way count
      thr_eff   = (CMP_W'(thr_ff) > CMP_W'(WAYS)) ? CMP_W'(WAYS) : CMP_W'(thr_ff);
      evict_now = is_insert && (used_cur != '0) && (CMP_W'(used_cur) >= thr_eff);

      valid_after = evict_now ? (valid_row & ~tail_vec) : valid_row;
      found_after = hit_any && !(evict_now && |(hit_vec & tail_vec));
      free_vec    = ~valid_after;
      first_free  = free_vec & (~free_vec + WAYS'(1));
      add_new     = is_insert && !found_after && |first_free;
      do_promote  = is_insert ? found_after : hit_any;
      promote_set = is_insert ? valid_after : valid_row;

      row_next = row_cur;
      for (int w = 0; w < WAYS; w++) begin
         if (evict_now && tail_vec[w]) begin
            row_next[w*ENTRY_W + OFS_AGE +: AGE_W]   = '0;
            row_next[w*ENTRY_W + OFS_REFS +: REFS_W] = '0;
         end
         if (do_promote) begin
            if (hit_vec[w]) begin
               row_next[w*ENTRY_W + OFS_AGE +: AGE_W] = '0;
               if (way_refs[w] != '1) begin
                  row_next[w*ENTRY_W + OFS_REFS +: REFS_W] = way_refs[w] + REFS_W'(1);
               end
            end else if (promote_set[w] && way_age[w] < hit_age) begin
               row_next[w*ENTRY_W + OFS_AGE +: AGE_W] = way_age[w] + AGE_W'(1);
            end
         end else if (add_new) begin
            if (first_free[w]) begin
               row_next[w*ENTRY_W +: KEY_W]              = stage_xid_ff;
               row_next[w*ENTRY_W + OFS_CSN +: CSN_W]    = stage_csn_ff;
               row_next[w*ENTRY_W + OFS_CLOG +: CLOG_W]  = stage_clog_ff;
               row_next[w*ENTRY_W + OFS_AGE +: AGE_W]    = '0;
               row_next[w*ENTRY_W + OFS_REFS +: REFS_W]  = '0;
            end else if (valid_after[w]) begin
               row_next[w*ENTRY_W + OFS_AGE +: AGE_W] = way_age[w] + AGE_W'(1);
            end
         end
      end

      valid_row_next = is_insert ? (valid_after | (add_new ? first_free : '0)) : valid_row;
      used_next      = used_cur - CNT_W'(evict_now) + CNT_W'(add_new);

      rsp_next.hit          = hit_any;
      rsp_next.csn_out      = (!is_insert && hit_any) ? hit_csn : '0;
      rsp_next.evicted      = evict_now;
      rsp_next.evicted_xid  = evict_now ? tail_key : '0;
      rsp_next.evicted_hits = evict_now ? tail_refs : '0;

      tot_evict_in = tot_evict_ff + TOTAL_W'(proc && evict_now);
      tot_refs_in  = (proc && evict_now) ? tot_refs_ff + TOTAL_W'(tail_refs) : tot_refs_ff;
   end

   // ------------------------------------------------------------------------
   // csr port
   // ------------------------------------------------------------------------
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thr_in     = (csr_wr && csr_paddr == CSR_EVICT_THRESHOLD) ? csr_pwdata[THR_W-1:0]
                                                                    : thr_ff;

   always_comb begin
      case (csr_paddr)
         CSR_EVICT_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         CSR_EVICTIONS_LO:    csr_prdata = tot_evict_ff[31:0];
         CSR_EVICTIONS_HI:    csr_prdata = tot_evict_ff[63:32];
         CSR_EVICT_REFS_LO:   csr_prdata = tot_refs_ff[31:0];
         CSR_EVICT_REFS_HI:   csr_prdata = tot_refs_ff[63:32];
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequential
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         thr_ff         <= THR_RESET;
         tot_evict_ff   <= '0;
         tot_refs_ff    <= '0;
         for (int p = 0; p < PARTITIONS; p++) begin
            valid_ff[p] <= '0;
            used_ff[p]  <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         thr_ff         <= thr_in;
         tot_evict_ff   <= tot_evict_in;
         tot_refs_ff    <= tot_refs_in;
         if (proc) begin
            fwd_valid_ff <= 1'b1;
         end
         for (int p = 0; p < PARTITIONS; p++) begin
            if (proc && stage_part_ff == PART_W'(p)) begin
               valid_ff[p] <= valid_row_next;
               used_ff[p]  <= used_next;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_mode_ff <= req_tuser[0];
         stage_xid_ff  <= req_xid;
         stage_csn_ff  <= req_csn;
         stage_clog_ff <= req_clog;
         stage_part_ff <= req_part;
      end
      if (proc) begin
         fwd_part_ff <= stage_part_ff;
         fwd_row_ff  <= row_next;
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_data_ff};

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   `PLC_ASSERT_NOW(a_fill_matches_valid, clock, reset, stage_valid_ff, $countones(valid_row) == int'(used_cur))
   `PLC_ASSERT_NOW(a_key_unique, clock, reset, stage_valid_ff, $onehot0(hit_vec))
   `PLC_ASSERT_NOW(a_tail_unique, clock, reset, proc && evict_now, $onehot(tail_vec))
   `PLC_ASSERT_NOW(a_room_for_new, clock, reset, proc && is_insert && !found_after, $onehot(first_free))
   `PLC_ASSERT_NEXT(a_result_loaded, clock, reset, proc, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: sim/tb_partitioned_lru_status_cache.sv
// ----------------------------------------------------------------------------
// tb_partitioned_lru_status_cache
// self-checking bench: directed and random request beats, lru cache predictor
// ----------------------------------------------------------------------------
// Request beats are driven at the falling edge and the response stream is
// sampled at the rising edge. A behavioral copy of the cache state predicts
// hit, csn, and eviction for each accepted request. Expected responses are
// queued in order and compared field by field. The evict threshold is
// rewritten over the csr port between phases, and only while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_partitioned_lru_status_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import plc_pkg::*;

   localparam int NPART = PLC_PARTITIONS;
   localparam int NWAY  = PLC_WAYS;
   localparam int NSLOT = NPART * NWAY;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic req_tvalid, req_tready;
   // xid, hash_code, new_csn, clog_status from bit 0 up, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   // mode
   logic [0:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   // hit, csn_out, evicted, evicted_xid, evicted_hits from bit 0 up, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   partitioned_lru_status_cache i_dut (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predicted cache contents
   logic [KEY_W-1:0]  cache_key  [NSLOT];
   logic [CSN_W-1:0]  cache_csn  [NSLOT];
   logic              cache_vld  [NSLOT];
   int unsigned       cache_age  [NSLOT];
   logic [REFS_W-1:0] cache_refs [NSLOT];
   int unsigned       part_fill  [NPART];
   logic [THR_W-1:0]  threshold;

   rsp_type expected_rsps[$];
   int  error_count;
   bit  no_idle;         // stretch with no idling on either side
   int  sink_holdoff;    // cycles the response side still holds off

   // keys reused often so that hits and refers happen
   logic [KEY_W-1:0] key_pool[16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

   // promote a slot to most recent and count its hit
   function automatic void promote_slot(int base, int slot);
      int a;
      a = cache_age[slot];
      for (int w = 0; w < NWAY; w++)
         if (cache_vld[base + w] && cache_age[base + w] < a) cache_age[base + w]++;
      cache_age[slot] = 0;
      if (cache_refs[slot] != '1) cache_refs[slot]++;
   endfunction

   // expected response of one request, updating the predicted cache
   function automatic rsp_type cache_access(logic mode, logic [KEY_W-1:0] xid,
                                            logic [HASH_W-1:0] hash,
                                            logic [CSN_W-1:0] csn);
      rsp_type r;
      int part, base, found, tail, thr;
      r = '0;
      part = hash % NPART;
      base = part * NWAY;
      found = -1;
      for (int w = 0; w < NWAY; w++)
         if (found < 0 && cache_vld[base + w] && cache_key[base + w] == xid)
            found = base + w;
      r.hit = (found >= 0);
      if (mode == MODE_LOOKUP) begin
         if (found >= 0) begin
            r.csn_out = cache_csn[found];
            promote_slot(base, found);
         end
         return r;
      end
      thr = (threshold > NWAY) ? NWAY : threshold;
      if (part_fill[part] > 0 && part_fill[part] >= thr) begin
         tail = -1;
         for (int w = 0; w < NWAY; w++)
            if (cache_vld[base + w] && (tail < 0 || cache_age[base + w] > cache_age[tail]))
               tail = base + w;
         if (tail >= 0) begin
            r.evicted = 1'b1;
            r.evicted_xid = cache_key[tail];
            r.evicted_hits = cache_refs[tail];
            cache_vld[tail] = 1'b0;
            cache_refs[tail] = '0;
            cache_age[tail] = 0;
            part_fill[part]--;
            if (tail == found) found = -1;
         end
      end
      if (found >= 0) begin
         promote_slot(base, found);
         return r;
      end
      for (int w = 0; w < NWAY; w++) begin
         if (!cache_vld[base + w]) begin
            for (int v = 0; v < NWAY; v++)
               if (cache_vld[base + v]) cache_age[base + v]++;
            cache_vld[base + w] = 1'b1;
            cache_key[base + w] = xid;
            cache_csn[base + w] = csn;
            cache_age[base + w] = 0;
            cache_refs[base + w] = '0;
            part_fill[part]++;
            break;
         end
      end
      return r;
   endfunction

   // send one request beat, with random idle cycles in front
   // valid stays high after the beat until the next call or wait_drained
   task automatic send_request(logic mode, logic [KEY_W-1:0] xid, logic [HASH_W-1:0] hash,
                               logic [CSN_W-1:0] csn, logic [CLOG_W-1:0] clog);
      while (!no_idle && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, clog, csn, hash, xid};
      do @(posedge clock); while (!req_tready);
      expected_rsps.push_back(cache_access(mode, xid, hash, csn));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // csr write with setup and access phases, done only with the block idle
   task automatic write_threshold(logic [THR_W-1:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_EVICT_THRESHOLD; csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      threshold = value;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic send_random(int count, int keyspace);
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(keyspace - 1)]
                                     : {$urandom, $urandom};
         send_request(1'($urandom_range(1)), k, $urandom, {$urandom, $urandom},
                      CLOG_W'($urandom_range(3)));
      end
   endtask

   // field extremes, both modes, empty partition, key equal to evicted tail
   task automatic test_directed();
      send_request(MODE_LOOKUP, '0, '0, '0, '0);                      // lookup empty
      send_request(MODE_INSERT, '0, '0, '1, 2'd3);
      send_request(MODE_LOOKUP, '0, '0, '0, '0);                      // hit
      send_request(MODE_INSERT, '1, '1, '0, 2'd0);
      send_request(MODE_LOOKUP, '1, 32'hffff_fffb, '0, '0);           // other hash, same partition
      send_request(MODE_LOOKUP, '1, '1, '1, 2'd3);
      send_request(MODE_INSERT, '1, '1, 64'h5555, 2'd1);              // refer
      wait_drained();
      write_threshold(5'd1);
      // threshold one: key present is the tail, evicted and added anew
      send_request(MODE_INSERT, '1, 32'h3, 64'hAAAA, 2'd2);
      send_request(MODE_LOOKUP, '1, 32'h3, '0, '0);
      send_request(MODE_INSERT, 64'h8000_0000_0000_0001, 32'h3, '1, 2'd3);
      wait_drained();
      write_threshold(5'd0);                                           // zero: evict unless empty
      send_request(MODE_INSERT, 64'h1234, 32'h2, 64'h1, 2'd1);
      send_request(MODE_INSERT, 64'h5678, 32'h2, 64'h2, 2'd2);
      send_request(MODE_INSERT, 64'h5678, 32'h2, 64'h3, 2'd0);
      wait_drained();
      write_threshold(5'd31);                                          // above way count
      for (int i = 0; i < 18; i++)
         send_request(MODE_INSERT, 64'(i + 100), 32'h1, 64'(i), 2'(i));
      wait_drained();
   endtask

   // several thresholds, each with random traffic on a small key pool
   task automatic test_random_thresholds();
      logic [THR_W-1:0] thr_list[6] = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd0, 5'd4};
      foreach (thr_list[i]) begin
         write_threshold(thr_list[i]);
         send_random(200, (i % 2) ? 16 : 8);
         wait_drained();
      end
   endtask

   // long response stall while requests keep coming, then back to back
   task automatic test_backpressure();
      write_threshold(5'd12);
      sink_holdoff = 60;
      send_random(80, 16);
      wait_drained();          // sender pause until all responses are in
      no_idle = 1'b1;
      send_random(150, 16);
      no_idle = 1'b0;
      wait_drained();
   endtask

   // response sink with random stalls and a counted hold-off
   always @(negedge clock) begin
      if (sink_holdoff > 0) begin
         rsp_tready <= 1'b0;
         sink_holdoff <= sink_holdoff - 1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 19);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_type)-1:0];
         if (expected_rsps.size() == 0) begin
            $error("unexpected response beat %h", got);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit exp %h got %h", want.hit, got.hit); error_count++;
            end
            if (got.csn_out !== want.csn_out) begin
               $error("csn_out exp %h got %h", want.csn_out, got.csn_out); error_count++;
            end
            if (got.evicted !== want.evicted) begin
               $error("evicted exp %h got %h", want.evicted, got.evicted); error_count++;
            end
            if (got.evicted_xid !== want.evicted_xid) begin
               $error("evicted_xid exp %h got %h", want.evicted_xid, got.evicted_xid);
               error_count++;
            end
            if (got.evicted_hits !== want.evicted_hits) begin
               $error("evicted_hits exp %h got %h", want.evicted_hits, got.evicted_hits);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 1'b0;
      error_count = 0; no_idle = 1'b0; sink_holdoff = 0;
      threshold = THR_RESET;
      for (int s = 0; s < NSLOT; s++) begin
         cache_key[s] = '0; cache_csn[s] = '0; cache_vld[s] = 1'b0;
         cache_age[s] = 0; cache_refs[s] = '0;
      end
      for (int p = 0; p < NPART; p++) part_fill[p] = 0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_thresholds();
      test_backpressure();

      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
